// ----- sv/hrf_pkg.sv -----
// Shared types and constants for the histogram rank fraction block.
package hrf_pkg;

  localparam int USER_W   = 12;
  localparam int PAGE_W   = 10;
  localparam int HIST_W   = 13;
  localparam int KNOWN_W  = 13;
  localparam int SHARE_W  = 17;
  localparam int USER_SLOTS = 1 << USER_W;
  localparam int HIST_BINS  = 1 << PAGE_W;
  // dividend is lower_users * 2^16, 28 bits wide
  localparam int DIV_W    = USER_W + SHARE_W - 1;
  localparam int DCNT_W   = $clog2(DIV_W);

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1 << (SHARE_W - 1));

  typedef enum logic [1:0] {
    HSEL_OLD,
    HSEL_NEW,
    HSEL_SWEEP
  } hist_sel_t;

  typedef enum logic [1:0] {
    RES_UNKNOWN,
    RES_SINGLE,
    RES_DIV
  } res_t;

  typedef struct packed {
    logic      clr_wr;
    logic      capture;
    logic      ld_user;
    hist_sel_t hist_sel;
    logic      hist_dec;
    logic      hist_inc;
    logic      rec_wr;
    logic      sw_clr;
    logic      sw_step;
    logic      div_init;
    logic      div_step;
    logic      fire;
    res_t      res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_query;
    logic seen;
    logic known_le1;
    logic sweep_done;
    logic div_last;
  } sts_t;

endpackage

// ----- sv/hrf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/hrf_ctrl.sv -----
// Sequencer for record, query, clearing pass and division.
module hrf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  hrf_pkg::sts_t sts,
  output hrf_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_RU,
    S_UW,
    S_DEC,
    S_DECW,
    S_INCR,
    S_INCW,
    S_SUM,
    S_SUM_TAIL,
    S_DIV_INIT,
    S_DIV,
    S_DIV_OUT
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.hist_sel = hrf_pkg::HSEL_SWEEP;
    cmd.res    = hrf_pkg::RES_DIV;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_RU;
        end
      end
      S_RU: state_next = S_UW;
      S_UW: begin
        cmd.ld_user = 1'b1;
        state_next  = S_DEC;
      end
      S_DEC: begin
        cmd.hist_sel = hrf_pkg::HSEL_OLD;
        if (!sts.op_query) begin
          state_next = sts.seen ? S_DECW : S_INCR;
        end else if (!sts.seen) begin
          cmd.fire   = 1'b1;
          cmd.res    = hrf_pkg::RES_UNKNOWN;
          state_next = S_IDLE;
        end else if (sts.known_le1) begin
          cmd.fire   = 1'b1;
          cmd.res    = hrf_pkg::RES_SINGLE;
          state_next = S_IDLE;
        end else begin
          cmd.sw_clr = 1'b1;
          state_next = S_SUM;
        end
      end
      S_DECW: begin
        cmd.hist_dec = 1'b1;
        state_next   = S_INCR;
      end
      S_INCR: begin
        cmd.hist_sel = hrf_pkg::HSEL_NEW;
        state_next   = S_INCW;
      end
      S_INCW: begin
        cmd.hist_inc = 1'b1;
        cmd.rec_wr   = 1'b1;
        state_next   = S_IDLE;
      end
      S_SUM: begin
        if (sts.sweep_done) begin
          state_next = S_SUM_TAIL;
        end else begin
          cmd.sw_step = 1'b1;
        end
      end
      S_SUM_TAIL: state_next = S_DIV_INIT;
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_DIV_OUT;
      end
      S_DIV_OUT: begin
        cmd.fire   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- sv/hrf_dp.sv -----
// Datapath: user and histogram memories, bin sweep, serial divider, result registers.
module hrf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          operation,
  input  logic [hrf_pkg::USER_W-1:0]    user_id,
  input  logic [hrf_pkg::PAGE_W-1:0]    page_in,
  input  hrf_pkg::cmd_t                 cmd,
  output hrf_pkg::sts_t                 sts,
  output logic                          done,
  output logic                          user_known,
  output logic [hrf_pkg::SHARE_W-1:0]   share,
  output logic [hrf_pkg::USER_W-1:0]    lower_cnt,
  output logic [hrf_pkg::USER_W-1:0]    other_users
);

  localparam int UW = hrf_pkg::USER_W;
  localparam int PW = hrf_pkg::PAGE_W;
  localparam int HW = hrf_pkg::HIST_W;
  localparam int DW = hrf_pkg::DIV_W;

  // captured transaction
  logic          op;
  logic [UW-1:0] slot;
  logic [PW-1:0] page;
  logic          seen;
  logic [PW-1:0] old;

  logic [UW-1:0]                 clr_cnt;
  logic [hrf_pkg::KNOWN_W-1:0]   known;
  logic [PW-1:0]                 sw_cnt;
  logic                          pend;
  logic [HW-1:0]                 acc;
  logic [UW-1:0]                 divisor;
  logic [UW-1:0]                 rem;
  logic [DW-1:0]                 quo;
  logic [hrf_pkg::DCNT_W-1:0]    dcnt;

  // user memory: {seen, page}
  logic          u_we;
  logic [UW-1:0] u_waddr;
  logic [PW:0]   u_wdata;
  logic [PW:0]   u_rdata;

  logic          h_we;
  logic [PW-1:0] h_waddr;
  logic [HW-1:0] h_wdata;
  logic [PW-1:0] h_raddr;
  logic [HW-1:0] h_rdata;

  logic [UW:0]   trial;

  hrf_ram #(.WIDTH(PW + 1), .DEPTH(hrf_pkg::USER_SLOTS)) u_user_mem (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (slot),
    .rdata (u_rdata)
  );

  hrf_ram #(.WIDTH(HW), .DEPTH(hrf_pkg::HIST_BINS)) u_hist_mem (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  always_comb begin
    u_we    = cmd.clr_wr | cmd.rec_wr;
    u_waddr = cmd.clr_wr ? clr_cnt : slot;
    u_wdata = cmd.clr_wr ? '0 : {1'b1, page};

    case (cmd.hist_sel)
      hrf_pkg::HSEL_OLD:   h_raddr = old;
      hrf_pkg::HSEL_NEW:   h_raddr = page;
      hrf_pkg::HSEL_SWEEP: h_raddr = sw_cnt;
      default:             h_raddr = sw_cnt;
    endcase

    h_we    = cmd.clr_wr | cmd.hist_dec | cmd.hist_inc;
    h_waddr = page;
    h_wdata = h_rdata + HW'(1);
    if (cmd.clr_wr) begin
      h_waddr = clr_cnt[PW-1:0];
      h_wdata = '0;
    end else if (cmd.hist_dec) begin
      h_waddr = old;
      // an empty bin stays empty
      h_wdata = (h_rdata != '0) ? h_rdata - HW'(1) : '0;
    end
  end

  assign trial = {rem, quo[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      known   <= '0;
      pend    <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_cnt <= clr_cnt + UW'(1);
      if (cmd.rec_wr && !seen) known <= known + hrf_pkg::KNOWN_W'(1);
      pend <= cmd.sw_step;
      done <= cmd.fire;
    end

    if (cmd.capture) begin
      op   <= operation;
      slot <= user_id;
      page <= page_in;
    end
    if (cmd.ld_user) begin
      seen <= u_rdata[PW];
      old  <= u_rdata[PW-1:0];
    end

    if (cmd.sw_clr) begin
      sw_cnt <= '0;
      acc    <= '0;
    end else begin
      if (cmd.sw_step) sw_cnt <= sw_cnt + PW'(1);
      if (pend) acc <= acc + h_rdata;
    end

    // restoring division, one quotient bit per cycle
    if (cmd.div_init) begin
      divisor <= UW'(known - hrf_pkg::KNOWN_W'(1));
      rem     <= '0;
      quo     <= {acc[UW-1:0], (DW - UW)'(0)};
      dcnt    <= '0;
    end else if (cmd.div_step) begin
      dcnt <= dcnt + hrf_pkg::DCNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem <= UW'(trial - {1'b0, divisor});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= trial[UW-1:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end

    if (cmd.fire) begin
      case (cmd.res)
        hrf_pkg::RES_UNKNOWN: begin
          user_known  <= 1'b0;
          share       <= '0;
          lower_cnt   <= '0;
          other_users <= '0;
        end
        hrf_pkg::RES_SINGLE: begin
          user_known  <= 1'b1;
          share       <= hrf_pkg::SHARE_ONE;
          lower_cnt   <= '0;
          other_users <= '0;
        end
        default: begin
          user_known  <= 1'b1;
          share       <= quo[hrf_pkg::SHARE_W-1:0];
          lower_cnt   <= acc[UW-1:0];
          other_users <= divisor;
        end
      endcase
    end
  end

  always_comb begin
    sts.clr_last   = (clr_cnt == '1);
    sts.op_query   = (op == hrf_pkg::OP_QUERY);
    sts.seen       = seen;
    sts.known_le1  = (known <= hrf_pkg::KNOWN_W'(1));
    sts.sweep_done = (sw_cnt == old);
    sts.div_last   = (dcnt == hrf_pkg::DCNT_W'(DW - 1));
  end

endmodule

// ----- sv/histogram_rank_fraction.sv -----
// Top level of the histogram rank fraction block: controller plus datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  request  | start & !busy           | operation, user_id, page_in
//  result   | done (one-cycle strobe) | user_known, share, lower_cnt, other_users
//
// A record reads the user's entry, decrements the old bin and increments the new
// bin; a user not seen before skips the decrement. A query of an unknown or lone
// user answers right after the user read; otherwise it sums the histogram bins
// below the queried user's page, one histogram bin per cycle, then runs a 28-step
// restoring divider. After reset a clearing pass wipes both memories, busy high.
// Only one transaction is in flight; results cannot be stalled.
module histogram_rank_fraction (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [hrf_pkg::USER_W-1:0]    user_id,
  input  logic [hrf_pkg::PAGE_W-1:0]    page_in,
  output logic                          done,
  output logic                          user_known,
  output logic [hrf_pkg::SHARE_W-1:0]   share,
  output logic [hrf_pkg::USER_W-1:0]    lower_cnt,
  output logic [hrf_pkg::USER_W-1:0]    other_users
);

  hrf_pkg::cmd_t cmd;
  hrf_pkg::sts_t sts;

  // sequencer: decides what the datapath does each cycle
  hrf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // memories, sweep accumulator, divider and result registers
  hrf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .operation   (operation),
    .user_id     (user_id),
    .page_in     (page_in),
    .cmd         (cmd),
    .sts         (sts),
    .done        (done),
    .user_known  (user_known),
    .share       (share),
    .lower_cnt   (lower_cnt),
    .other_users (other_users)
  );

`ifndef SYNTHESIS
  // clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy after reset");

  // unknown user gives an all-zero result
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    done && !user_known |-> share == '0 && lower_cnt == '0 && other_users == '0)
    else $error("unknown user result not zero");

  // lone user reads as full share
  a_single_full: assert property (@(posedge clk) disable iff (rst)
    done && user_known && other_users == '0 |-> share == hrf_pkg::SHARE_ONE)
    else $error("lone user share not 1.0");

  // share never above 1.0 and lower count never above divisor
  a_share_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> share <= hrf_pkg::SHARE_ONE && lower_cnt <= other_users)
    else $error("share out of range");
`endif

endmodule
